// ===== hw/rtl/zoomed_tile_map_pixel_renderer_core_assert.svh =====
// Assertion macros for the tile map renderer.
`ifndef ZOOMED_TILE_MAP_PIXEL_RENDERER_CORE_ASSERT_SVH
`define ZOOMED_TILE_MAP_PIXEL_RENDERER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ZTMR_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ZTMR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ZTMR_ASSERT(label, ante, cons)
`define ZTMR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== hw/rtl/ztmr_pkg.sv =====
package ztmr_pkg;

   localparam int PIXEL_W      = 10;
   localparam int VIEW_W       = 11;
   localparam int CENTER_X_W   = 25;
   localparam int CENTER_Y_W   = 24;
   localparam int INV_SCALE_W  = 21;
   localparam int CELL_INDEX_W = 15;
   localparam int REGION_W     = 8;
   localparam int COLOR_W      = 16;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 25;

   localparam int DELTA_W  = PIXEL_W + 2;
   localparam int PROD_W   = DELTA_W + INV_SCALE_W + 1;
   localparam int GCOORD_W = PROD_W + 1;
   localparam int FRAC_W   = 16;
   localparam int CELL_W   = GCOORD_W - 1 - FRAC_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [REGION_W-1:0] NO_REGION        = 8'hFF;
   localparam logic [COLOR_W-1:0]  COLOR_BACKGROUND = 16'h112A;
   localparam logic [COLOR_W-1:0]  COLOR_GRID_LINE  = 16'h4208;
   localparam logic [COLOR_W-1:0]  COLOR_NONE       = 16'h0000;
   localparam int                  PALETTE_SIZE     = 12;

   localparam logic [COLOR_W-1:0] PALETTE [PALETTE_SIZE] = '{
      16'h9D70, 16'hC50B, 16'h8D56, 16'hB430, 16'hA4D7, 16'h95B5,
      16'hC5EC, 16'h95CE, 16'hB515, 16'h8CF8, 16'hAD75, 16'hBCEA
   };

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VIEW_WIDTH  = 3'd0,
      CSR_VIEW_HEIGHT = 3'd1,
      CSR_CENTER_X    = 3'd2,
      CSR_CENTER_Y    = 3'd3,
      CSR_INV_SCALE   = 3'd4,
      CSR_SHOW_GRID   = 3'd5
   } csr_index_type;

   typedef enum logic {
      OP_RENDER = 1'b0,
      OP_WRITE  = 1'b1
   } op_type;

   typedef struct packed {
      logic [VIEW_W-1:0]      view_width;
      logic [VIEW_W-1:0]      view_height;
      logic [CENTER_X_W-1:0]  center_x;
      logic [CENTER_Y_W-1:0]  center_y;
      logic [INV_SCALE_W-1:0] inv_scale;
      logic                   show_grid;
   } cfg_type;

   typedef struct packed {
      logic                  empty;
      logic                  full;
      logic [QCOUNT_W-1:0]   count;
   } queue_status_type;

   typedef struct packed {
      op_type                  op;
      logic signed [PROD_W-1:0] vx;
      logic signed [PROD_W-1:0] vy;
      logic [CELL_INDEX_W-1:0] cell_index;
      logic [REGION_W-1:0]     cell_region;
   } mid_entry_type;

   typedef struct packed {
      logic [COLOR_W-1:0]  color;
      logic [REGION_W-1:0] region_id;
      logic                on_map;
   } result_type;

   // value below 96 reduced mod 12
   function automatic logic [3:0] mod12_small(input logic [6:0] v);
      logic [6:0] r;
      r = v;
      if (r >= 7'd48) r = r - 7'd48;
      if (r >= 7'd24) r = r - 7'd24;
      if (r >= 7'd12) r = r - 7'd12;
      return r[3:0];
   endfunction

   // (id*7+3) mod 12, using 16 = 4 (mod 12)
   function automatic logic [3:0] palette_index(input logic [REGION_W-1:0] id);
      logic [3:0] m;
      logic [6:0] t;
      m = mod12_small({1'b0, id[7:4], 2'b00} + {3'b000, id[3:0]});
      t = {3'b000, m} * 7'd7 + 7'd3;
      return mod12_small(t);
   endfunction

endpackage

// ===== hw/rtl/ztmr_queue.sv =====
module ztmr_queue import ztmr_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head_data,
   output queue_status_type status
);

   logic [WIDTH-1:0]    slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      status.empty = (count_ff == '0);
      status.full  = (count_ff == QCOUNT_W'(QUEUE_DEPTH));
      status.count = count_ff;
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      wr_ptr_in    = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in    = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in     = count_ff + QCOUNT_W'(do_push) - QCOUNT_W'(do_pop);
      head_data    = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/ztmr_front.sv =====
module ztmr_front import ztmr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic                    req_op,
   input  logic [PIXEL_W-1:0]      req_pixel_x,
   input  logic [PIXEL_W-1:0]      req_pixel_y,
   input  logic [CELL_INDEX_W-1:0] req_cell_index,
   input  logic [REGION_W-1:0]     req_cell_region,
   input  cfg_type                 cfg,
   input  queue_status_type        mid_status,
   output logic                    mid_push,
   output mid_entry_type           mid_entry
);

   logic                         s1_valid_ff, s1_valid_in;
   mid_entry_type                s1_ff, s1_in;
   logic                         load;
   logic signed [DELTA_W-1:0]    dx, dy;
   logic signed [INV_SCALE_W:0]  inv_s;

   // twice the offset of the pixel centre from the view centre, times inv_scale
   always_comb begin
      inv_s = $signed({1'b0, cfg.inv_scale});
      dx = $signed({1'b0, req_pixel_x, 1'b1}) - $signed({1'b0, cfg.view_width});
      dy = $signed({1'b0, req_pixel_y, 1'b1}) - $signed({1'b0, cfg.view_height});
      s1_in.op          = op_type'(req_op);
      s1_in.vx          = dx * inv_s;
      s1_in.vy          = dy * inv_s;
      s1_in.cell_index  = req_cell_index;
      s1_in.cell_region = req_cell_region;

      req_full    = s1_valid_ff && mid_status.full;
      mid_push    = s1_valid_ff && !mid_status.full;
      load        = req_push && !req_full;
      s1_valid_in = load ? 1'b1 : (mid_push ? 1'b0 : s1_valid_ff);
      mid_entry   = s1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_ff <= s1_in;
      end
   end

endmodule

// ===== hw/rtl/ztmr_back.sv =====
module ztmr_back import ztmr_pkg::*; #(
   parameter int GRID_WIDTH   = 256,
   parameter int GRID_HEIGHT  = 128,
   parameter int REGION_COUNT = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  queue_status_type mid_status,
   input  mid_entry_type    mid_entry,
   output logic             mid_pop,
   input  queue_status_type out_status,
   output logic             out_push,
   output result_type       out_result
);

   localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
   localparam int CELL_SPACE = 1 << CELL_INDEX_W;
   localparam int MEM_DEPTH  = (CELL_COUNT < CELL_SPACE) ? CELL_COUNT : CELL_SPACE;
   localparam int ADDR_W     = $clog2(MEM_DEPTH);
   localparam int FULL_W     = $clog2(CELL_COUNT);
   localparam int XW         = $clog2(GRID_WIDTH);
   localparam int YW         = $clog2(GRID_HEIGHT);

   typedef struct packed {
      op_type                  op;
      logic [GCOORD_W-1:0]     gx;
      logic [GCOORD_W-1:0]     gy;
      logic [CELL_INDEX_W-1:0] cell_index;
      logic [REGION_W-1:0]     cell_region;
   } stage_a_type;

   logic [REGION_W-1:0] grid_mem [MEM_DEPTH];

   logic                     issue;
   logic                     a_valid_ff;
   stage_a_type              a_ff, a_in;
   logic signed [PROD_W-1:0] half_x, half_y;

   logic                b_valid_ff;
   op_type              b_op_ff;
   logic                b_on_ff, b_on_in;
   logic                b_hit_ff, b_hit_in;
   logic [REGION_W-1:0] b_rd_ff;

   logic                in_x, in_y;
   logic [XW-1:0]       cx;
   logic [YW-1:0]       cy;
   logic [FULL_W-1:0]   addr_full;
   logic [ADDR_W-1:0]   rd_addr, wr_addr;
   logic                wr_en;

   // issue only with room in the output queue for everything in flight
   always_comb begin
      issue = !mid_status.empty &&
              (out_status.count + QCOUNT_W'(a_valid_ff) + QCOUNT_W'(b_valid_ff)
               < QCOUNT_W'(QUEUE_DEPTH));
      mid_pop = issue;

      half_x = mid_entry.vx >>> 1;
      half_y = mid_entry.vy >>> 1;
      a_in.op          = mid_entry.op;
      a_in.gx          = GCOORD_W'(half_x) + GCOORD_W'(cfg.center_x);
      a_in.gy          = GCOORD_W'(half_y) + GCOORD_W'(cfg.center_y);
      a_in.cell_index  = mid_entry.cell_index;
      a_in.cell_region = mid_entry.cell_region;
   end

   // stage B: cell lookup and grid write
   always_comb begin
      in_x = !a_ff.gx[GCOORD_W-1] &&
             (a_ff.gx[GCOORD_W-2:FRAC_W] < CELL_W'(GRID_WIDTH));
      in_y = !a_ff.gy[GCOORD_W-1] &&
             (a_ff.gy[GCOORD_W-2:FRAC_W] < CELL_W'(GRID_HEIGHT));
      cx = a_ff.gx[FRAC_W +: XW];
      cy = a_ff.gy[FRAC_W +: YW];
      addr_full = FULL_W'(cy) * FULL_W'(GRID_WIDTH) + FULL_W'(cx);
      rd_addr   = addr_full[ADDR_W-1:0];
      wr_addr   = a_ff.cell_index[ADDR_W-1:0];
      wr_en     = a_valid_ff && (a_ff.op == OP_WRITE) &&
                  (32'(a_ff.cell_index) < CELL_COUNT);
      b_on_in   = in_x && in_y;
      b_hit_in  = cfg.show_grid &&
                  (({{(INV_SCALE_W-FRAC_W){1'b0}}, a_ff.gx[FRAC_W-1:0]} < cfg.inv_scale) ||
                   ({{(INV_SCALE_W-FRAC_W){1'b0}}, a_ff.gy[FRAC_W-1:0]} < cfg.inv_scale));
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         grid_mem[wr_addr] <= a_ff.cell_region;
      end
      b_rd_ff <= grid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= issue;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         a_ff <= a_in;
      end
      b_op_ff  <= a_ff.op;
      b_on_ff  <= b_on_in;
      b_hit_ff <= b_hit_in;
   end

   // stage C: colour
   always_comb begin
      out_push = b_valid_ff;
      if (b_op_ff == OP_WRITE) begin
         out_result.color     = COLOR_NONE;
         out_result.region_id = NO_REGION;
         out_result.on_map    = 1'b0;
      end else if (!b_on_ff) begin
         out_result.color     = COLOR_BACKGROUND;
         out_result.region_id = NO_REGION;
         out_result.on_map    = 1'b0;
      end else begin
         out_result.region_id = b_rd_ff;
         out_result.on_map    = 1'b1;
         if (b_rd_ff == NO_REGION) begin
            out_result.color = COLOR_BACKGROUND;
         end else if (b_hit_ff) begin
            out_result.color = COLOR_GRID_LINE;
         end else if (32'(b_rd_ff) < REGION_COUNT) begin
            out_result.color = PALETTE[palette_index(b_rd_ff)];
         end else begin
            out_result.color = COLOR_BACKGROUND;
         end
      end
   end

endmodule

// ===== hw/rtl/zoomed_tile_map_pixel_renderer_core.sv =====
// Channel   Direction  Handshake             Payload
// req_      in         push / full           op, pixel_x, pixel_y, cell_index, cell_region
// rsp_      out        empty / pop           color, region_id, on_map
// csr_      in         write (no wait)       index, data
//
// One item per cycle sustained while rsp_pop keeps draining results; from accept to result
// an item passes the multiply stage, queue, coordinate add and cell memory read port.
// Reset restores register defaults and empties both queues; the cell grid is not cleared.
// A stalled rsp_pop fills the output queue, the back end then holds items in the
// middle queue, and req_full rises once that queue and the front stage are full.
`include "zoomed_tile_map_pixel_renderer_core_assert.svh"

module zoomed_tile_map_pixel_renderer_core import ztmr_pkg::*; #(
   parameter int GRID_WIDTH   = 256,
   parameter int GRID_HEIGHT  = 128,
   parameter int REGION_COUNT = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic                    req_op,
   input  logic [PIXEL_W-1:0]      req_pixel_x,
   input  logic [PIXEL_W-1:0]      req_pixel_y,
   input  logic [CELL_INDEX_W-1:0] req_cell_index,
   input  logic [REGION_W-1:0]     req_cell_region,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [COLOR_W-1:0]      rsp_color,
   output logic [REGION_W-1:0]     rsp_region_id,
   output logic                    rsp_on_map,
   input  logic                    csr_write,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   cfg_type                      cfg_ff;
   queue_status_type             mid_status, out_status;
   logic                         mid_push, mid_pop, out_push;
   mid_entry_type                mid_in_entry, mid_head_entry;
   logic [$bits(mid_entry_type)-1:0] mid_head;
   result_type                   out_result, out_head_result;
   logic [$bits(result_type)-1:0] out_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.view_width  <= 11'd320;
         cfg_ff.view_height <= 11'd240;
         cfg_ff.center_x    <= 25'd8388608;
         cfg_ff.center_y    <= 24'd4194304;
         cfg_ff.inv_scale   <= 21'd65536;
         cfg_ff.show_grid   <= 1'b1;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_VIEW_WIDTH:  cfg_ff.view_width  <= csr_data[VIEW_W-1:0];
            CSR_VIEW_HEIGHT: cfg_ff.view_height <= csr_data[VIEW_W-1:0];
            CSR_CENTER_X:    cfg_ff.center_x    <= csr_data[CENTER_X_W-1:0];
            CSR_CENTER_Y:    cfg_ff.center_y    <= csr_data[CENTER_Y_W-1:0];
            CSR_INV_SCALE:   cfg_ff.inv_scale   <= csr_data[INV_SCALE_W-1:0];
            CSR_SHOW_GRID:   cfg_ff.show_grid   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   ztmr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_op          (req_op),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .req_cell_index  (req_cell_index),
      .req_cell_region (req_cell_region),
      .cfg             (cfg_ff),
      .mid_status      (mid_status),
      .mid_push        (mid_push),
      .mid_entry       (mid_in_entry)
   );

   ztmr_queue #(
      .WIDTH ($bits(mid_entry_type))
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in_entry),
      .pop       (mid_pop),
      .head_data (mid_head),
      .status    (mid_status)
   );

   assign mid_head_entry = mid_entry_type'(mid_head);

   ztmr_back #(
      .GRID_WIDTH   (GRID_WIDTH),
      .GRID_HEIGHT  (GRID_HEIGHT),
      .REGION_COUNT (REGION_COUNT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .mid_status (mid_status),
      .mid_entry  (mid_head_entry),
      .mid_pop    (mid_pop),
      .out_status (out_status),
      .out_push   (out_push),
      .out_result (out_result)
   );

   ztmr_queue #(
      .WIDTH ($bits(result_type))
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_result),
      .pop       (rsp_pop),
      .head_data (out_head),
      .status    (out_status)
   );

   always_comb begin
      out_head_result = result_type'(out_head);
      rsp_empty       = out_status.empty;
      rsp_color       = out_head_result.color;
      rsp_region_id   = out_head_result.region_id;
      rsp_on_map      = out_head_result.on_map;
   end

   `ZTMR_ASSERT(a_out_credit, out_push, !out_status.full)
   `ZTMR_ASSERT(a_mid_credit, mid_push, !mid_status.full)
   `ZTMR_ASSERT(a_full_only_when_stalled, req_full, mid_status.full)
   `ZTMR_ASSERT_NEXT(a_pop_drains, rsp_pop && !rsp_empty && !out_push, out_status.count == $past(out_status.count) - 3'd1)

endmodule
